@@ sv/frl_pkg.sv @@
// ----------------------------------------------------------------------------
// frl_pkg - shared types and constants
// Sizes, register indexes and sequencer states of the Farrow I/Q resampler.
// ----------------------------------------------------------------------------
package frl_pkg;

    localparam int POLY_ROWS  = 4;
    localparam int POLY_TAPS  = 4;
    localparam int ROW_W      = (POLY_ROWS > 1) ? $clog2(POLY_ROWS) : 1;
    localparam int TAP_W      = (POLY_TAPS > 1) ? $clog2(POLY_TAPS) : 1;
    localparam int COEF_DEPTH = POLY_ROWS * POLY_TAPS;
    localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

    // shared multiplier operand and product widths
    localparam int MUL_AW = 41;
    localparam int MUL_BW = 26;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // fir sum, room for up to eight 58-bit products
    localparam int SUM_W = 62;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    localparam logic [1:0] CFG_RATIO   = 2'd0;
    localparam logic [1:0] CFG_ATTACK  = 2'd1;
    localparam logic [1:0] CFG_RELEASE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_FIR_MUL,
        ST_FIR_ACC,
        ST_OUT_MUL,
        ST_OUT_ACC,
        ST_SQI_MUL,
        ST_SQI_ACC,
        ST_SQQ_MUL,
        ST_SQQ_ACC,
        ST_LVL_MUL,
        ST_LVL_ACC,
        ST_INT_INIT,
        ST_INT_MUL,
        ST_INT_ACC,
        ST_DONE
    } state_t;

endpackage

@@ sv/farrow_iq_resampler_level.sv @@
// ----------------------------------------------------------------------------
// farrow_iq_resampler_level - transposed Farrow downsampler with level tracker
// I/Q samples feed a transposed Farrow structure; results come out on wrap.
// ----------------------------------------------------------------------------
// a sample without output runs the phase, power, level and integrator steps before the
// next one is taken; a sample with output also runs the fir and output steps, and a held
// result stalls it in its last step
// every multiply goes through the single shared registered multiplier
// coefficient writes are taken while idle and leave the sequencer idle
// aresetn (sync, active low) clears phase, filter state, level and output valid, and sets config registers to defaults
module farrow_iq_resampler_level (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [24:0]  cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_req_type,
    input  logic signed [15:0] s_sample_i,
    input  logic signed [15:0] s_sample_q,
    input  logic [2:0]   s_coef_row,
    input  logic [2:0]   s_coef_col,
    input  logic signed [17:0] s_coef_value,
    output logic         m_valid,
    input  logic         m_ready,
    output logic signed [15:0] m_out_i,
    output logic signed [15:0] m_out_q,
    output logic [31:0]  m_signal_level
);

    localparam int MPW = frl_pkg::MUL_PW;
    localparam int SW  = frl_pkg::SUM_W;

    frl_pkg::state_t state_reg, state_next;

    logic [24:0] ratio_reg;
    logic [23:0] attack_reg;
    logic [23:0] release_reg;

    logic [24:0] mu_reg;
    logic [31:0] level_reg;
    logic        dump_reg;
    logic signed [15:0] si_reg, sq_reg;
    logic        ch_reg;
    logic [frl_pkg::ROW_W-1:0] row_reg;
    logic [frl_pkg::TAP_W-1:0] tap_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [16:0] p_reg;
    logic [31:0] abs2_reg;
    logic signed [15:0] res_i_reg, res_q_reg;
    logic signed [17:0] coef_rd_reg;

    logic signed [39:0] integ_i_reg [frl_pkg::POLY_TAPS];
    logic signed [39:0] integ_q_reg [frl_pkg::POLY_TAPS];
    logic signed [47:0] accum_i_reg [frl_pkg::POLY_ROWS];
    logic signed [47:0] accum_q_reg [frl_pkg::POLY_ROWS];
    logic signed [17:0] coef_mem [frl_pkg::COEF_DEPTH];

    logic        m_valid_reg;
    logic signed [15:0] m_out_i_reg, m_out_q_reg;
    logic [31:0] m_level_reg;

    logic signed [frl_pkg::MUL_AW-1:0] op_a;
    logic signed [frl_pkg::MUL_BW-1:0] op_b;
    logic signed [MPW-1:0] prod;

    logic        s_accept;
    logic        row_last, tap_last;
    logic [24:0] ratio_eff;
    logic signed [25:0] mu_diff;
    logic [frl_pkg::COEF_AW-1:0] coef_wr_idx, coef_rd_idx;
    logic [frl_pkg::ROW_W-1:0] row_rd;
    logic [frl_pkg::TAP_W-1:0] tap_rd;
    logic        coef_wr_ok;
    logic signed [39:0] integ_sel;
    logic signed [47:0] accum_sel, accum0_sel;
    logic signed [39:0] acc0_clamped;
    logic signed [SW-1:0] sum_next, sum_rnd;
    logic signed [SW-1:0] acc_add;
    logic signed [47:0] acc_new;
    logic signed [MPW-1:0] prod_rnd, prod_sh;
    logic signed [15:0] out_sat;
    logic signed [16:0] p_new;
    logic signed [32:0] lvl_diff;
    logic [23:0] lvl_coef;
    logic signed [33:0] lvl_new;
    logic        out_free;
    logic        out_load;

    frl_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign s_accept  = s_valid && s_ready;
    assign row_last  = (row_reg == frl_pkg::ROW_W'(frl_pkg::POLY_ROWS - 1));
    assign tap_last  = (tap_reg == frl_pkg::TAP_W'(frl_pkg::POLY_TAPS - 1));
    assign ratio_eff = (ratio_reg > frl_pkg::ONE_Q24) ? frl_pkg::ONE_Q24 : ratio_reg;
    assign mu_diff   = $signed({1'b0, mu_reg}) - $signed({1'b0, ratio_eff});
    assign out_free  = !m_valid_reg || m_ready;
    assign out_load  = (state_reg == frl_pkg::ST_DONE) && dump_reg && out_free;

    assign coef_wr_ok  = (32'(s_coef_row) < frl_pkg::POLY_ROWS)
                      && (32'(s_coef_col) < frl_pkg::POLY_TAPS);
    assign coef_wr_idx = frl_pkg::COEF_AW'(32'(s_coef_row) * frl_pkg::POLY_TAPS
                                           + 32'(s_coef_col));

    // coefficient address of the next multiply, read into a register in the state before it
    always_comb begin
        row_rd = row_reg;
        tap_rd = tap_reg;
        if (state_reg == frl_pkg::ST_PHASE) begin
            row_rd = '0;
            tap_rd = '0;
        end else if (state_reg == frl_pkg::ST_FIR_ACC) begin
            if (tap_last) begin
                tap_rd = '0;
                row_rd = row_last ? '0 : row_reg + 1'b1;
            end else begin
                tap_rd = tap_reg + 1'b1;
            end
        end
    end

    assign coef_rd_idx = frl_pkg::COEF_AW'(32'(row_rd) * frl_pkg::POLY_TAPS
                                           + 32'(tap_rd));

    assign integ_sel  = ch_reg ? integ_q_reg[tap_reg] : integ_i_reg[tap_reg];
    assign accum_sel  = ch_reg ? accum_q_reg[row_reg] : accum_i_reg[row_reg];
    assign accum0_sel = ch_reg ? accum_q_reg[0] : accum_i_reg[0];

    always_comb begin
        if (accum0_sel > 48'sh007F_FFFF_FFFF) begin
            acc0_clamped = 40'sh7F_FFFF_FFFF;
        end else if (accum0_sel < -48'sh0080_0000_0000) begin
            acc0_clamped = -40'sh80_0000_0000;
        end else begin
            acc0_clamped = accum0_sel[39:0];
        end
    end

    // fir accumulate and row dump with 48-bit saturation
    assign sum_next = sum_reg + SW'(prod);
    assign sum_rnd  = (sum_next + SW'(32768)) >>> 16;
    assign acc_add  = SW'(accum_sel) + sum_rnd;
    always_comb begin
        if (acc_add > SW'(48'sh7FFF_FFFF_FFFF)) begin
            acc_new = 48'sh7FFF_FFFF_FFFF;
        end else if (acc_add < -SW'(48'sh7FFF_FFFF_FFFF) - SW'(1)) begin
            acc_new = -48'sh7FFF_FFFF_FFFF - 48'sd1;
        end else begin
            acc_new = acc_add[47:0];
        end
    end

    // round by 2^24 on the product, shared by output, level and powers of mu
    assign prod_rnd = prod + MPW'(24'h80_0000);
    assign prod_sh  = prod_rnd >>> 24;
    always_comb begin
        if (prod_sh > MPW'(32767)) begin
            out_sat = 16'sh7FFF;
        end else if (prod_sh < -MPW'(32768)) begin
            out_sat = -16'sh8000;
        end else begin
            out_sat = prod_sh[15:0];
        end
    end
    assign p_new = prod_sh[16:0];

    assign lvl_diff = $signed({1'b0, abs2_reg}) - $signed({1'b0, level_reg});
    assign lvl_coef = (abs2_reg > level_reg) ? attack_reg : release_reg;
    assign lvl_new  = $signed({2'b0, level_reg}) + prod_sh[33:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            frl_pkg::ST_IDLE: begin
                if (s_accept && !s_req_type) begin
                    state_next = frl_pkg::ST_PHASE;
                end
            end
            frl_pkg::ST_PHASE: begin
                state_next = mu_diff[25] ? frl_pkg::ST_FIR_MUL : frl_pkg::ST_SQI_MUL;
            end
            frl_pkg::ST_FIR_MUL: state_next = frl_pkg::ST_FIR_ACC;
            frl_pkg::ST_FIR_ACC: begin
                if (tap_last && row_last && ch_reg) begin
                    state_next = frl_pkg::ST_OUT_MUL;
                end else begin
                    state_next = frl_pkg::ST_FIR_MUL;
                end
            end
            frl_pkg::ST_OUT_MUL: state_next = frl_pkg::ST_OUT_ACC;
            frl_pkg::ST_OUT_ACC: begin
                state_next = ch_reg ? frl_pkg::ST_SQI_MUL : frl_pkg::ST_OUT_MUL;
            end
            frl_pkg::ST_SQI_MUL: state_next = frl_pkg::ST_SQI_ACC;
            frl_pkg::ST_SQI_ACC: state_next = frl_pkg::ST_SQQ_MUL;
            frl_pkg::ST_SQQ_MUL: state_next = frl_pkg::ST_SQQ_ACC;
            frl_pkg::ST_SQQ_ACC: state_next = frl_pkg::ST_LVL_MUL;
            frl_pkg::ST_LVL_MUL: state_next = frl_pkg::ST_LVL_ACC;
            frl_pkg::ST_LVL_ACC: state_next = frl_pkg::ST_INT_INIT;
            frl_pkg::ST_INT_INIT: begin
                state_next = (frl_pkg::POLY_TAPS > 1) ? frl_pkg::ST_INT_MUL
                                                      : frl_pkg::ST_DONE;
            end
            frl_pkg::ST_INT_MUL: state_next = frl_pkg::ST_INT_ACC;
            frl_pkg::ST_INT_ACC: begin
                state_next = (tap_last && ch_reg) ? frl_pkg::ST_DONE
                                                  : frl_pkg::ST_INT_MUL;
            end
            frl_pkg::ST_DONE: begin
                if (!dump_reg || out_free) begin
                    state_next = frl_pkg::ST_IDLE;
                end
            end
            default: state_next = frl_pkg::ST_IDLE;
        endcase
    end

    // handshake and multiplier operand select
    always_comb begin
        s_ready = 1'b0;
        op_a    = '0;
        op_b    = '0;
        case (state_reg)
            frl_pkg::ST_IDLE: s_ready = aresetn;
            frl_pkg::ST_FIR_MUL: begin
                op_a = frl_pkg::MUL_AW'(integ_sel);
                op_b = frl_pkg::MUL_BW'(coef_rd_reg);
            end
            frl_pkg::ST_OUT_MUL: begin
                op_a = frl_pkg::MUL_AW'(acc0_clamped);
                op_b = $signed({1'b0, ratio_eff});
            end
            frl_pkg::ST_SQI_MUL: begin
                op_a = frl_pkg::MUL_AW'(si_reg);
                op_b = frl_pkg::MUL_BW'(si_reg);
            end
            frl_pkg::ST_SQQ_MUL: begin
                op_a = frl_pkg::MUL_AW'(sq_reg);
                op_b = frl_pkg::MUL_BW'(sq_reg);
            end
            frl_pkg::ST_LVL_MUL: begin
                op_a = frl_pkg::MUL_AW'(lvl_diff);
                op_b = $signed({2'b0, lvl_coef});
            end
            frl_pkg::ST_INT_MUL: begin
                op_a = frl_pkg::MUL_AW'(p_reg);
                op_b = $signed({1'b0, mu_reg});
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_req_type && coef_wr_ok) begin
            coef_mem[coef_wr_idx] <= s_coef_value;
        end
        coef_rd_reg <= coef_mem[coef_rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= frl_pkg::ST_IDLE;
            ratio_reg   <= 25'd8388608;
            attack_reg  <= 24'd167772;
            release_reg <= 24'd1678;
            mu_reg      <= '0;
            level_reg   <= '0;
            dump_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < frl_pkg::POLY_TAPS; k++) begin
                integ_i_reg[k] <= '0;
                integ_q_reg[k] <= '0;
            end
            for (int k = 0; k < frl_pkg::POLY_ROWS; k++) begin
                accum_i_reg[k] <= '0;
                accum_q_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_addr)
                    frl_pkg::CFG_RATIO:   ratio_reg   <= cfg_wdata;
                    frl_pkg::CFG_ATTACK:  attack_reg  <= cfg_wdata[23:0];
                    frl_pkg::CFG_RELEASE: release_reg <= cfg_wdata[23:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                frl_pkg::ST_IDLE: begin
                    if (s_accept && !s_req_type) begin
                        si_reg <= s_sample_i;
                        sq_reg <= s_sample_q;
                    end
                end
                frl_pkg::ST_PHASE: begin
                    ch_reg  <= 1'b0;
                    row_reg <= '0;
                    tap_reg <= '0;
                    sum_reg <= '0;
                    if (mu_diff[25]) begin
                        mu_reg   <= mu_diff[24:0] + frl_pkg::ONE_Q24;
                        dump_reg <= 1'b1;
                    end else begin
                        mu_reg   <= mu_diff[24:0];
                        dump_reg <= 1'b0;
                    end
                end
                frl_pkg::ST_FIR_ACC: begin
                    if (tap_last) begin
                        sum_reg <= '0;
                        tap_reg <= '0;
                        if (ch_reg) begin
                            accum_q_reg[row_reg] <= acc_new;
                        end else begin
                            accum_i_reg[row_reg] <= acc_new;
                        end
                        if (row_last) begin
                            row_reg <= '0;
                            ch_reg  <= !ch_reg;
                        end else begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end else begin
                        sum_reg <= sum_next;
                        tap_reg <= tap_reg + 1'b1;
                    end
                end
                frl_pkg::ST_OUT_ACC: begin
                    if (ch_reg) begin
                        res_q_reg <= out_sat;
                        // shift accumulators down, clear integrators
                        for (int k = 0; k < frl_pkg::POLY_ROWS - 1; k++) begin
                            accum_i_reg[k] <= accum_i_reg[k + 1];
                            accum_q_reg[k] <= accum_q_reg[k + 1];
                        end
                        accum_i_reg[frl_pkg::POLY_ROWS - 1] <= '0;
                        accum_q_reg[frl_pkg::POLY_ROWS - 1] <= '0;
                        for (int k = 0; k < frl_pkg::POLY_TAPS; k++) begin
                            integ_i_reg[k] <= '0;
                            integ_q_reg[k] <= '0;
                        end
                    end else begin
                        res_i_reg <= out_sat;
                    end
                    ch_reg <= !ch_reg;
                end
                frl_pkg::ST_SQI_ACC: abs2_reg <= prod[31:0];
                frl_pkg::ST_SQQ_ACC: abs2_reg <= abs2_reg + prod[31:0];
                frl_pkg::ST_LVL_ACC: level_reg <= lvl_new[31:0];
                frl_pkg::ST_INT_INIT: begin
                    integ_i_reg[0] <= integ_i_reg[0] + 40'(si_reg);
                    integ_q_reg[0] <= integ_q_reg[0] + 40'(sq_reg);
                    p_reg   <= 17'(si_reg);
                    ch_reg  <= 1'b0;
                    tap_reg <= frl_pkg::TAP_W'(1);
                end
                frl_pkg::ST_INT_ACC: begin
                    if (ch_reg) begin
                        integ_q_reg[tap_reg] <= integ_q_reg[tap_reg] + 40'(p_new);
                    end else begin
                        integ_i_reg[tap_reg] <= integ_i_reg[tap_reg] + 40'(p_new);
                    end
                    if (tap_last) begin
                        ch_reg  <= 1'b1;
                        tap_reg <= frl_pkg::TAP_W'(1);
                        p_reg   <= 17'(sq_reg);
                    end else begin
                        tap_reg <= tap_reg + 1'b1;
                        p_reg   <= p_new;
                    end
                end
                frl_pkg::ST_DONE: begin
                    if (out_load) begin
                        m_out_i_reg <= res_i_reg;
                        m_out_q_reg <= res_q_reg;
                        m_level_reg <= level_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_i        = m_out_i_reg;
    assign m_out_q        = m_out_q_reg;
    assign m_signal_level = m_level_reg;

    // phase stays below one after every update
    a_mu_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mu_reg[24] == 1'b0)
        else $error("phase out of range");

    // tracked level never exceeds the largest possible power
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= 32'h8000_0000)
        else $error("level out of range");

    // a sample transaction makes the block busy on the next cycle
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_req_type) |=> !s_ready)
        else $error("ready after sample transaction");

    // a result is only loaded after a phase wrap
    a_result_on_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> dump_reg)
        else $error("result without dump");

endmodule

@@ sv/frl_mul.sv @@
// ----------------------------------------------------------------------------
// frl_mul - shared signed multiplier
// One registered signed multiply, reused by every multiply step of the sequencer.
// ----------------------------------------------------------------------------
module frl_mul (
    input  logic                                aclk,
    input  logic signed [frl_pkg::MUL_AW-1:0]   op_a,
    input  logic signed [frl_pkg::MUL_BW-1:0]   op_b,
    output logic signed [frl_pkg::MUL_PW-1:0]   prod
);

    logic signed [frl_pkg::MUL_PW-1:0] prod_reg;
    logic signed [frl_pkg::MUL_PW-1:0] prod_next;

    assign prod_next = frl_pkg::MUL_PW'(op_a) * frl_pkg::MUL_PW'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ test/farrow_iq_resampler_level_tb.sv @@
// ----------------------------------------------------------------------------
// farrow_iq_resampler_level_tb - self-checking bench for the Farrow resampler
// Loads coefficient tables, sweeps ratio and level rates through extreme and
// random settings, sends directed and random I/Q samples with random idling on
// both sides, and checks every output against a fixed-point predictor.
// ----------------------------------------------------------------------------
module farrow_iq_resampler_level_tb;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 120;

    typedef struct {
        logic signed [15:0] out_i;
        logic signed [15:0] out_q;
        logic [31:0]        level;
    } resampled_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_addr = '0;
    logic [24:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_req_type = 1'b0;
    logic signed [15:0] s_sample_i = '0;
    logic signed [15:0] s_sample_q = '0;
    logic [2:0]         s_coef_row = '0;
    logic [2:0]         s_coef_col = '0;
    logic signed [17:0] s_coef_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_out_i;
    logic signed [15:0] m_out_q;
    logic [31:0]        m_signal_level;

    farrow_iq_resampler_level DUT (.*);

    always #1 aclk = ~aclk;

    // predictor state
    longint     ratio_q24, attack_q24, release_q24;
    longint     mu_q24, level_q30;
    longint     integ [2][frl_pkg::POLY_TAPS];
    longint     accum [2][frl_pkg::POLY_ROWS];
    longint     coef_tab [frl_pkg::COEF_DEPTH];
    resampled_t resampled_q [$];

    int send_idle = 0;
    int recv_idle = 0;
    int errors = 0;
    int stall_cnt = 0;

    function automatic longint round_sh(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint wrap40(longint v);
        return (v <<< 24) >>> 24;
    endfunction

    function automatic void predict_sample(longint si, longint sq);
        longint r, sum, abs2, c, p, smp;
        longint outv [2];
        resampled_t res;
        bit dumped;
        dumped = 0;
        r = ratio_q24 > 64'sd16777216 ? 64'sd16777216 : ratio_q24;
        mu_q24 -= r;
        if (mu_q24 < 0) begin
            mu_q24 += 64'sd16777216;
            dumped = 1;
            for (int ch = 0; ch < 2; ch++) begin
                for (int n = 0; n < frl_pkg::POLY_ROWS; n++) begin
                    sum = 0;
                    for (int m = 0; m < frl_pkg::POLY_TAPS; m++)
                        sum += integ[ch][m] * coef_tab[n*frl_pkg::POLY_TAPS + m];
                    accum[ch][n] = clip(accum[ch][n] + round_sh(sum, 16),
                                        -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
                end
                outv[ch] = clip(round_sh(clip(accum[ch][0], -(64'sd1 <<< 39),
                                (64'sd1 <<< 39) - 1) * r, 24), -32768, 32767);
                for (int n = 0; n + 1 < frl_pkg::POLY_ROWS; n++)
                    accum[ch][n] = accum[ch][n+1];
                accum[ch][frl_pkg::POLY_ROWS-1] = 0;
                for (int m = 0; m < frl_pkg::POLY_TAPS; m++)
                    integ[ch][m] = 0;
            end
        end
        abs2 = si*si + sq*sq;
        c = abs2 > level_q30 ? attack_q24 : release_q24;
        level_q30 += round_sh(c * (abs2 - level_q30), 24);
        for (int ch = 0; ch < 2; ch++) begin
            smp = ch == 0 ? si : sq;
            p = smp;
            integ[ch][0] = wrap40(integ[ch][0] + p);
            for (int m = 1; m < frl_pkg::POLY_TAPS; m++) begin
                p = round_sh(p * mu_q24, 24);
                integ[ch][m] = wrap40(integ[ch][m] + p);
            end
        end
        if (dumped) begin
            res.out_i = outv[0][15:0];
            res.out_q = outv[1][15:0];
            res.level = level_q30[31:0];
            resampled_q.push_back(res);
        end
    endfunction

    task automatic send_item(bit req, logic signed [15:0] si, logic signed [15:0] sq,
                             logic [2:0] row, logic [2:0] col, logic signed [17:0] cv);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_sample_i   <= si;
        s_sample_q   <= sq;
        s_coef_row   <= row;
        s_coef_col   <= col;
        s_coef_value <= cv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (req) begin
            if (row < frl_pkg::POLY_ROWS && col < frl_pkg::POLY_TAPS)
                coef_tab[row*frl_pkg::POLY_TAPS + col] = longint'(cv);
        end else begin
            predict_sample(longint'(si), longint'(sq));
        end
    endtask

    task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq);
        send_item(1'b0, si, sq, 3'($urandom), 3'($urandom), 18'($urandom));
    endtask

    task automatic send_coef(logic [2:0] row, logic [2:0] col, logic signed [17:0] cv);
        send_item(1'b1, 16'($urandom), 16'($urandom), row, col, cv);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (resampled_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [24:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            frl_pkg::CFG_RATIO:   ratio_q24   = longint'(val);
            frl_pkg::CFG_ATTACK:  attack_q24  = longint'(val[23:0]);
            frl_pkg::CFG_RELEASE: release_q24 = longint'(val[23:0]);
            default: ;
        endcase
    endtask

    task automatic load_random_table();
        for (int n = 0; n < frl_pkg::POLY_ROWS; n++)
            for (int m = 0; m < frl_pkg::POLY_TAPS; m++)
                send_coef(3'(n), 3'(m), 18'($urandom));
    endtask

    task automatic test_coef_load();
        // extreme values into every entry first
        for (int n = 0; n < frl_pkg::POLY_ROWS; n++)
            for (int m = 0; m < frl_pkg::POLY_TAPS; m++)
                send_coef(3'(n), 3'(m), ((n + m) % 2) ? 18'sh1FFFF : 18'sh20000);
        // out of range writes are dropped
        send_coef(3'd7, 3'd0, 18'sh1FFFF);
        send_coef(3'd0, 3'd7, 18'sh20000);
        send_coef(3'd5, 3'd6, 18'sh15555);
    endtask

    task automatic test_directed_samples();
        logic signed [15:0] vals [5] = '{16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001};
        foreach (vals[k]) begin
            send_sample(vals[k], vals[k]);
            send_sample(vals[k], -vals[k]);
        end
        wait_idle();
        load_random_table();
        for (int k = 0; k < 6; k++) send_sample(16'($urandom), 16'($urandom));
        wait_idle();
    endtask

    task automatic test_ratio_extremes();
        // index beyond the register list must do nothing
        write_reg(2'd3, 25'h1FFFFFF);
        write_reg(frl_pkg::CFG_RATIO, 25'h1FFFFFF);
        write_reg(frl_pkg::CFG_ATTACK, 25'hFFFFFF);
        write_reg(frl_pkg::CFG_RELEASE, 25'd0);
        for (int k = 0; k < 8; k++) send_sample(16'($urandom), 16'($urandom));
        wait_idle();
        write_reg(frl_pkg::CFG_RATIO, 25'h1000000);
        write_reg(frl_pkg::CFG_ATTACK, 25'd0);
        write_reg(frl_pkg::CFG_RELEASE, 25'hFFFFFF);
        for (int k = 0; k < 8; k++) send_sample(16'($urandom), 16'($urandom));
        wait_idle();
        // tiny ratio: at most one wrap, zero ratio: never
        write_reg(frl_pkg::CFG_RATIO, 25'd1);
        for (int k = 0; k < 4; k++) send_sample(16'($urandom), 16'($urandom));
        wait_idle();
        write_reg(frl_pkg::CFG_RATIO, 25'd0);
        for (int k = 0; k < 4; k++) send_sample(16'($urandom), 16'($urandom));
        wait_idle();
    endtask

    task automatic test_random(int n_items);
        logic signed [15:0] si, sq;
        write_reg(frl_pkg::CFG_RATIO, 25'($urandom_range(25'h1000000, 25'h100000)));
        write_reg(frl_pkg::CFG_ATTACK, 25'($urandom_range(25'hFFFFFF, 0)));
        write_reg(frl_pkg::CFG_RELEASE, 25'($urandom_range(25'h3FFFF, 0)));
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 4) begin
                send_coef(3'($urandom), 3'($urandom), 18'($urandom));
                continue;
            end
            si = 16'($urandom);
            sq = 16'($urandom);
            if ($urandom_range(9) == 0) si = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
            if ($urandom_range(9) == 0) sq = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
            if ($urandom_range(3) == 0) begin
                si = si >>> $urandom_range(14);
                sq = sq >>> $urandom_range(14);
            end
            send_sample(si, sq);
            if (k == n_items / 2) begin
                // hold off until the pipe runs dry
                s_valid <= 1'b0;
                @(posedge aclk);
                while (resampled_q.size() != 0) @(posedge aclk);
            end
        end
        wait_idle();
    endtask

    // result checking and receiver stalls
    always @(posedge aclk) begin
        resampled_t want;
        if (aresetn && m_valid && m_ready) begin
            if (resampled_q.size() == 0) begin
                $display("%0t: unexpected transaction i=%0d q=%0d level=%0d",
                         $time, m_out_i, m_out_q, m_signal_level);
                errors++;
            end else begin
                want = resampled_q.pop_front();
                if (m_out_i !== want.out_i) begin
                    $display("%0t: out_i expected %0d actual %0d", $time, want.out_i, m_out_i);
                    errors++;
                end
                if (m_out_q !== want.out_q) begin
                    $display("%0t: out_q expected %0d actual %0d", $time, want.out_q, m_out_q);
                    errors++;
                end
                if (m_signal_level !== want.level) begin
                    $display("%0t: signal_level expected %0d actual %0d",
                             $time, want.level, m_signal_level);
                    errors++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("farrow_iq_resampler_level_tb NOT OK");
            $finish;
        end
    end

    initial begin
        ratio_q24   = 8388608;
        attack_q24  = 167772;
        release_q24 = 1678;
        mu_q24      = 0;
        level_q30   = 0;
        foreach (integ[c, m]) integ[c][m] = 0;
        foreach (accum[c, n]) accum[c][n] = 0;
        foreach (coef_tab[k]) coef_tab[k] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_idle = 32;
        recv_idle = 45;
        test_coef_load();
        test_directed_samples();
        test_ratio_extremes();
        test_random(650);
        send_idle = 45;
        recv_idle = 32;
        test_random(650);
        send_idle = 0;
        recv_idle = 0;
        test_random(650);

        if (errors == 0)
            $display("farrow_iq_resampler_level_tb OK");
        else
            $display("farrow_iq_resampler_level_tb NOT OK");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/frl_pkg.sv
sv/frl_mul.sv
sv/farrow_iq_resampler_level.sv
test/farrow_iq_resampler_level_tb.sv
